/* rtl/bpmp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial product modulo a prime: shared definitions
// Field widths, the prime modulus and the modular adder used by the datapath.
// ----------------------------------------------------------------------------
package bpmp_pkg;

    localparam int COUNT_W   = 11;
    localparam int RESIDUE_W = 30;
    localparam int BIT_W     = $clog2(RESIDUE_W);

    localparam logic [RESIDUE_W-1:0] PRIME_MOD = RESIDUE_W'(1000000007);

    typedef logic [RESIDUE_W-1:0] residue_t;

    // Sum of two residues, reduced once; both operands must lie below the prime.
    function automatic residue_t mod_add(input residue_t x, input residue_t y);
        logic [RESIDUE_W:0] sum;
        logic [RESIDUE_W:0] red;
        sum = {1'b0, x} + {1'b0, y};
        red = sum - {1'b0, PRIME_MOD};
        if (sum >= {1'b0, PRIME_MOD})
        begin
            return red[RESIDUE_W-1:0];
        end
        return sum[RESIDUE_W-1:0];
    endfunction

endpackage

/* rtl/binomial_product_mod_prime_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial product modulo a prime
// Returns C(m,k) * C(n,k) mod 1000000007, with each binomial built by Pascal's
// rule in a scratch row memory and the product formed by double-and-add.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the result appears on
// product_residue for the single cycle in which done is high and must be taken
// then, as the block cannot be stalled. Counts above MAX_COUNT are saturated.
// Each binomial C(x,k) with 0 < k < x is built row by row over rows i = 1..x,
// updating min(i,k) entries per row, after a setup step and before a read-out.
// The single modular adder and the one read and one write port of the row
// memory set the pace, retiring one Pascal entry per cycle within a row, with
// row set-up states (S_ROW, and S_HEAD for rows with i > k) between rows;
// trivial binomials are resolved at setup. The final product is formed on the
// same adder, a doubling and a conditional add per bit of the second residue, with busy high throughout a request.
module binomial_product_mod_prime_top #(
    parameter int MAX_COUNT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [bpmp_pkg::COUNT_W-1:0]     first_count,
    input  logic [bpmp_pkg::COUNT_W-1:0]     second_count,
    input  logic [bpmp_pkg::COUNT_W-1:0]     choose_count,
    output logic                             done,
    output logic [bpmp_pkg::RESIDUE_W-1:0]   product_residue
);

    localparam int CW = $clog2(MAX_COUNT + 1);

    typedef logic [CW-1:0] cnt_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_ROW,
        S_HEAD,
        S_RUN,
        S_TAIL,
        S_FIN,
        S_DBL,
        S_ADDB
    } state_t;

    state_t                        state_reg, state_next;
    logic                          phase_reg, phase_next;
    cnt_t                          m_reg, m_next;
    cnt_t                          n_reg, n_next;
    cnt_t                          k_reg, k_next;
    cnt_t                          i_reg, i_next;
    cnt_t                          issue_reg, issue_next;
    logic                          pend_valid_reg, pend_valid_next;
    cnt_t                          pend_j_reg, pend_j_next;
    logic                          done_reg, done_next;
    bpmp_pkg::residue_t            result_reg, result_next;
    logic [bpmp_pkg::BIT_W-1:0]    bit_reg, bit_next;

    bpmp_pkg::residue_t            upper_reg, upper_next;
    bpmp_pkg::residue_t            a_reg, a_next;
    bpmp_pkg::residue_t            b_reg, b_next;
    bpmp_pkg::residue_t            acc_reg, acc_next;

    bpmp_pkg::residue_t            row_mem [0:MAX_COUNT];
    bpmp_pkg::residue_t            rdata_reg;
    logic                          mem_we;
    cnt_t                          waddr;
    cnt_t                          raddr;
    bpmp_pkg::residue_t            wdata;

    bpmp_pkg::residue_t            add_a;
    bpmp_pkg::residue_t            add_b;
    bpmp_pkg::residue_t            add_sum;

    cnt_t                          x_cur;
    cnt_t                          top;
    bpmp_pkg::residue_t            lower;
    bpmp_pkg::residue_t            bin_val;
    logic                          bin_ready;
    cnt_t                          m_clamp;
    cnt_t                          n_clamp;
    cnt_t                          k_clamp;

    assign add_sum = bpmp_pkg::mod_add(add_a, add_b);

    assign m_clamp = (32'(first_count) > 32'(MAX_COUNT)) ? CW'(MAX_COUNT) : CW'(first_count);
    assign n_clamp = (32'(second_count) > 32'(MAX_COUNT)) ? CW'(MAX_COUNT)
                                                          : CW'(second_count);
    assign k_clamp = (32'(choose_count) > 32'(MAX_COUNT)) ? CW'(MAX_COUNT)
                                                          : CW'(choose_count);

    assign x_cur = phase_reg ? n_reg : m_reg;
    assign top   = (i_reg < k_reg) ? i_reg : k_reg;
    assign lower = (pend_j_reg == CW'(1)) ? bpmp_pkg::RESIDUE_W'(1) : rdata_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        m_next          = m_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        issue_next      = issue_reg;
        pend_valid_next = pend_valid_reg;
        pend_j_next     = pend_j_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        bit_next        = bit_reg;
        upper_next      = upper_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        mem_we          = 1'b0;
        waddr           = pend_j_reg;
        wdata           = add_sum;
        raddr           = top;
        add_a           = upper_reg;
        add_b           = lower;
        bin_val         = '0;
        bin_ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    m_next     = m_clamp;
                    n_next     = n_clamp;
                    k_next     = k_clamp;
                    phase_next = 1'b0;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (k_reg > x_cur)
                begin
                    bin_val   = '0;
                    bin_ready = 1'b1;
                end
                else if ((k_reg == '0) || (k_reg == x_cur))
                begin
                    bin_val   = bpmp_pkg::RESIDUE_W'(1);
                    bin_ready = 1'b1;
                end
                else
                begin
                    i_next     = CW'(1);
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                issue_next      = top;
                pend_valid_next = 1'b0;
                if (top == i_reg)
                begin
                    upper_next = '0;
                    state_next = S_RUN;
                end
                else
                begin
                    raddr      = top;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                upper_next = rdata_reg;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (pend_valid_reg)
                begin
                    mem_we     = 1'b1;
                    upper_next = lower;
                end
                if (issue_reg != '0)
                begin
                    raddr           = issue_reg - CW'(1);
                    pend_valid_next = 1'b1;
                    pend_j_next     = issue_reg;
                    issue_next      = issue_reg - CW'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    if (i_reg == x_cur)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_ROW;
                    end
                end
            end
            S_TAIL:
            begin
                raddr      = k_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                bin_val   = rdata_reg;
                bin_ready = 1'b1;
            end
            S_DBL:
            begin
                add_a      = acc_reg;
                add_b      = acc_reg;
                acc_next   = add_sum;
                state_next = S_ADDB;
            end
            S_ADDB:
            begin
                add_a = acc_reg;
                add_b = a_reg;
                if (b_reg[bit_reg])
                begin
                    acc_next = add_sum;
                end
                if (bit_reg == '0)
                begin
                    result_next = b_reg[bit_reg] ? add_sum : acc_reg;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    bit_next   = bit_reg - bpmp_pkg::BIT_W'(1);
                    state_next = S_DBL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (bin_ready)
        begin
            if (!phase_reg)
            begin
                a_next     = bin_val;
                phase_next = 1'b1;
                state_next = S_SETUP;
            end
            else
            begin
                b_next     = bin_val;
                acc_next   = '0;
                bit_next   = bpmp_pkg::BIT_W'(bpmp_pkg::RESIDUE_W - 1);
                state_next = S_DBL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= 1'b0;
            m_reg          <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            i_reg          <= '0;
            issue_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_j_reg     <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            bit_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            m_reg          <= m_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
            issue_reg      <= issue_next;
            pend_valid_reg <= pend_valid_next;
            pend_j_reg     <= pend_j_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
            bit_reg        <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        upper_reg <= upper_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[waddr] <= wdata;
        end
        rdata_reg <= row_mem[raddr];
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign product_residue = result_reg;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("Result strobe without a request in progress.");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (product_residue < bpmp_pkg::PRIME_MOD))
        else $error("Result is not reduced below the prime.");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted request did not raise busy.");

    a_write_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (wdata < bpmp_pkg::PRIME_MOD) && (waddr != '0))
        else $error("Row memory write is unreduced or hits the fixed entry.");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe lasted more than one cycle.");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the binomial product modulo a prime
// Sends directed and random requests, predicts C(m,k) * C(n,k) mod 1000000007
// with an independent Pascal row calculation and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          MAX_COUNT    = 1024;
    localparam longint      PRIME        = 64'd1000000007;
    localparam int unsigned IDLE_LIMIT   = 6000000;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct {
        int unsigned                      serial;
        logic [bpmp_pkg::COUNT_W-1:0]     first_set;
        logic [bpmp_pkg::COUNT_W-1:0]     second_set;
        logic [bpmp_pkg::COUNT_W-1:0]     choice;
        bpmp_pkg::residue_t               residue;
    } pending_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic [bpmp_pkg::COUNT_W-1:0]     first_count = '0;
    logic [bpmp_pkg::COUNT_W-1:0]     second_count = '0;
    logic [bpmp_pkg::COUNT_W-1:0]     choose_count = '0;
    logic                             busy;
    logic                             done;
    bpmp_pkg::residue_t               product_residue;

    pending_t             expected_results[$];
    int unsigned          sent_count = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          idle_cycles = 0;

    binomial_product_mod_prime_top #(
        .MAX_COUNT(MAX_COUNT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .first_count(first_count),
        .second_count(second_count),
        .choose_count(choose_count),
        .done(done),
        .product_residue(product_residue)
    );

    always #1 clk = ~clk;

    function automatic int unsigned saturate_count(input logic [bpmp_pkg::COUNT_W-1:0] v);
        if (v > MAX_COUNT)
        begin
            return MAX_COUNT;
        end
        return 32'(v);
    endfunction

    function automatic longint binomial_residue(input int unsigned x, input int unsigned k);
        longint row [0:MAX_COUNT];
        longint sum;
        int     i;
        int     j;
        int     top;
        if (k > x)
        begin
            return 0;
        end
        if (k == 0 || k == x)
        begin
            return 1;
        end
        for (i = 0; i <= k; i++)
        begin
            row[i] = 0;
        end
        row[0] = 1;
        for (i = 1; i <= x; i++)
        begin
            top = (i < k) ? i : k;
            for (j = top; j >= 1; j--)
            begin
                sum = row[j] + row[j-1];
                if (sum >= PRIME)
                begin
                    sum -= PRIME;
                end
                row[j] = sum;
            end
        end
        return row[k];
    endfunction

    function automatic bpmp_pkg::residue_t predicted_product(
        input logic [bpmp_pkg::COUNT_W-1:0] m,
        input logic [bpmp_pkg::COUNT_W-1:0] n,
        input logic [bpmp_pkg::COUNT_W-1:0] k);
        longint a;
        longint b;
        a = binomial_residue(saturate_count(m), saturate_count(k));
        b = binomial_residue(saturate_count(n), saturate_count(k));
        return bpmp_pkg::residue_t'((a * b) % PRIME);
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%s", what);
        end
    endtask

    task automatic send_request(input logic [bpmp_pkg::COUNT_W-1:0] m,
                                input logic [bpmp_pkg::COUNT_W-1:0] n,
                                input logic [bpmp_pkg::COUNT_W-1:0] k);
        int unsigned pick;
        int unsigned gap;
        pending_t    req;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            gap = 0;
        end
        else if (pick < 90)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(10, 60);
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        first_count  <= m;
        second_count <= n;
        choose_count <= k;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        req.serial     = sent_count;
        req.first_set  = m;
        req.second_set = n;
        req.choice     = k;
        req.residue    = predicted_product(m, n, k);
        expected_results.push_back(req);
        sent_count++;
    endtask

    task automatic test_zero_choice();
        send_request(11'd0, 11'd0, 11'd0);
        send_request(11'd1024, 11'd1024, 11'd0);
        send_request(11'd2047, 11'd2047, 11'd0);
        send_request(11'd37, 11'd5, 11'd0);
    endtask

    task automatic test_choice_exceeds_set();
        send_request(11'd3, 11'd10, 11'd5);
        send_request(11'd10, 11'd3, 11'd5);
        send_request(11'd0, 11'd0, 11'd1);
        send_request(11'd1023, 11'd1024, 11'd1024);
        send_request(11'd7, 11'd7, 11'd7);
        send_request(11'd7, 11'd9, 11'd7);
    endtask

    task automatic test_saturation();
        send_request(11'd2047, 11'd1024, 11'd2047);
        send_request(11'd1500, 11'd2000, 11'd1024);
        send_request(11'd2047, 11'd5, 11'd3);
        send_request(11'd1025, 11'd1030, 11'd1);
    endtask

    task automatic test_large_sets();
        send_request(11'd1024, 11'd1024, 11'd1);
        send_request(11'd1024, 11'd1024, 11'd2);
        send_request(11'd1024, 11'd1, 11'd1);
        send_request(11'd66, 11'd34, 11'd17);
        send_request(11'd100, 11'd200, 11'd50);
        send_request(11'd600, 11'd600, 11'd300);
    endtask

    task automatic test_random_mix();
        int unsigned                      pick;
        logic [bpmp_pkg::COUNT_W-1:0]     m;
        logic [bpmp_pkg::COUNT_W-1:0]     n;
        logic [bpmp_pkg::COUNT_W-1:0]     k;
        repeat (80)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                m = bpmp_pkg::COUNT_W'($urandom_range(0, 40));
                n = bpmp_pkg::COUNT_W'($urandom_range(0, 40));
                k = bpmp_pkg::COUNT_W'($urandom_range(0, 24));
            end
            else if (pick < 75)
            begin
                m = bpmp_pkg::COUNT_W'($urandom_range(0, 2047));
                n = bpmp_pkg::COUNT_W'($urandom_range(0, 2047));
                k = bpmp_pkg::COUNT_W'($urandom_range(0, 3));
            end
            else if (pick < 90)
            begin
                m = bpmp_pkg::COUNT_W'($urandom_range(0, 2047));
                n = bpmp_pkg::COUNT_W'($urandom_range(0, 2047));
                k = bpmp_pkg::COUNT_W'($urandom_range(1025, 2047));
            end
            else
            begin
                m = bpmp_pkg::COUNT_W'($urandom_range(0, 120));
                n = bpmp_pkg::COUNT_W'($urandom_range(0, 120));
                k = bpmp_pkg::COUNT_W'($urandom_range(0, 60));
            end
            send_request(m, n, k);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_choice();
        test_choice_exceeds_set();
        test_saturation();
        test_large_sets();
        test_random_mix();
        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("binomial_product_mod_prime_top verification clean");
        end
        else
        begin
            $display("binomial_product_mod_prime_top verification failed");
        end
        $finish;
    end

    always @(posedge clk)
    begin
        pending_t head;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result: product_residue %0d",
                                        product_residue));
            end
            else
            begin
                head = expected_results.pop_front();
                if (product_residue !== head.residue)
                begin
                    note_mismatch($sformatf(
                        "request %0d (%0d, %0d, %0d): product_residue expected %0d, got %0d",
                        head.serial, head.first_set, head.second_set, head.choice,
                        head.residue, product_residue));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("binomial_product_mod_prime_top verification failed");
            $finish;
        end
    end

endmodule
